// ===== rtl/core/es2c_pkg.sv =====
// shared types and constants for the epoch seconds to calendar converter
`timescale 1ns / 1ps
`default_nettype none
package es2c_pkg;

  localparam int unsigned SecsInDay  = 86400;
  localparam int unsigned SecsInHour = 3600;
  localparam int unsigned SecsInMin  = 60;
  // day number offset so that every 32-bit input gives a non-negative day
  localparam int unsigned DayBias    = 24856;

  typedef struct packed {
    logic [16:0] tod;
    logic [15:0] day;
  } split_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [7:0] yoff;
    logic [8:0] yday;
    logic [4:0] mday;
    logic [3:0] month;
  } cal_t;

  // cumulative days before each month, plus one from March on in a leap year
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] v;
    case (m)
      4'd0: v = 9'd0;
      4'd1: v = 9'd31;
      4'd2: v = 9'd59;
      4'd3: v = 9'd90;
      4'd4: v = 9'd120;
      4'd5: v = 9'd151;
      4'd6: v = 9'd181;
      4'd7: v = 9'd212;
      4'd8: v = 9'd243;
      4'd9: v = 9'd273;
      4'd10: v = 9'd304;
      4'd11: v = 9'd334;
      default: v = 9'd0;
    endcase
    if (leap && m >= 4'd2) v = v + 9'd1;
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/es2c_split.sv =====
// seconds to biased day number and time of day, three stages
`timescale 1ns / 1ps
`default_nettype none
module es2c_split
  import es2c_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [31:0] secs,
  output logic             out_valid,
  output split_t           out
);
  // biased seconds: t + DayBias*86400 is non-negative and needs 33 bits
  localparam logic [32:0] Bias = 33'(DayBias) * 33'(SecsInDay);
  // reciprocal 2^48/86400 rounded up
  localparam logic [31:0] Recip = 32'd3257812231;

  logic        v1, v2;
  logic [32:0] u1;
  logic [32:0] u2;
  logic [63:0] prod2;
  logic [15:0] q2;
  logic [32:0] r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1 <= {{1{secs[31]}}, secs} + Bias;
      u2 <= u1;
      prod2 <= 64'(u1) * 64'(Recip);
    end
  end

  always_comb begin
    q2 = prod2[63:48];
    r2 = u2 - 33'(q2) * 33'(SecsInDay);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (r2 >= 33'(SecsInDay)) begin
        out.day <= q2 + 16'd1;
        out.tod <= 17'(r2 - 33'(SecsInDay));
      end else begin
        out.day <= q2;
        out.tod <= r2[16:0];
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/es2c_fields.sv =====
// time of day, weekday, year and month, several stages
`timescale 1ns / 1ps
`default_nettype none
module es2c_fields
  import es2c_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  split_t    in,
  output logic      out_valid,
  output cal_t      out
);
  // reciprocals, rounded up: 2^27/3600, 2^23/60, 2^19/7, 2^26/1461
  localparam logic [31:0] HourRecip = 32'd37283;
  localparam logic [33:0] MinRecip  = 34'd139811;
  localparam logic [31:0] WeekRecip = 32'd74899;
  localparam logic [31:0] YearRecip = 32'd45934;

  logic        v1, v2, v3;
  logic [15:0] dd;
  logic [15:0] dw;
  logic [31:0] hprod;
  logic [33:0] mprod;
  logic [31:0] wprod;
  logic [31:0] yprod;
  logic [16:0] tod1;
  logic [4:0]  h1;
  logic [10:0] mod1;
  logic [15:0] dw1;
  logic [12:0] wq1;
  logic [15:0] d1;
  logic [5:0]  yc1;
  logic [5:0]  mi2, s2;
  logic [4:0]  h2, h3;
  logic [5:0]  mi3, s3;
  logic [2:0]  w2, w3;
  logic [10:0] rd2;
  logic [5:0]  yc2;
  logic [7:0]  y3;
  logic [8:0]  yday3;
  logic        leap3;
  logic [4:0]  md;
  logic [3:0]  mo;
  logic [1:0]  c4;
  logic [8:0]  ydc;
  logic [7:0]  ycal;

  // 1901-01-01 is 25202 days before the epoch; biased day 0 is DayBias before it
  assign dd = in.day + 16'(25202) - 16'(DayBias);
  // 1901-01-01 was a Tuesday
  assign dw = dd + 16'd2;

  assign hprod = 32'(in.tod) * HourRecip;
  assign mprod = 34'(in.tod) * MinRecip;
  assign wprod = 32'(dw) * WeekRecip;
  assign yprod = 32'(dd) * YearRecip;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  // stage 1: hour, minute of day, week and four-year quotients
  always_ff @(posedge clk) begin
    if (en) begin
      tod1 <= in.tod;
      h1 <= hprod[31:27];
      mod1 <= mprod[33:23];
      dw1 <= dw;
      wq1 <= wprod[31:19];
      d1 <= dd;
      yc1 <= yprod[31:26];
    end
  end

  // stage 2: remainders
  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= 6'(tod1 - 17'(mod1) * 17'(SecsInMin));
      mi2 <= 6'(mod1 - 11'(h1) * 11'(SecsInMin));
      h2 <= h1;
      w2 <= 3'(dw1 - 16'(wq1) * 16'd7);
      rd2 <= 11'(d1 - 16'(yc1) * 16'd1461);
      yc2 <= yc1;
    end
  end

  // stage 3: year within the four-year cycle (no skipped leap in 1901..2099)
  always_comb begin
    if (rd2 >= 11'd1095) begin
      c4 = 2'd3;
      ydc = 9'(rd2 - 11'd1095);
    end else if (rd2 >= 11'd730) begin
      c4 = 2'd2;
      ydc = 9'(rd2 - 11'd730);
    end else if (rd2 >= 11'd365) begin
      c4 = 2'd1;
      ydc = 9'(rd2 - 11'd365);
    end else begin
      c4 = 2'd0;
      ydc = rd2[8:0];
    end
    ycal = 8'd1 + {yc2, 2'b00} + {6'd0, c4};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mi3 <= mi2;
      s3 <= s2;
      h3 <= h2;
      w3 <= w2;
      y3 <= ycal;
      yday3 <= ydc;
      leap3 <= (ycal[1:0] == 2'd0);
    end
  end

  // stage 4: month search over the cumulative table
  always_comb begin
    mo = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (yday3 >= month_start(4'(i), leap3)) mo = 4'(i);
    end
    md = 5'(yday3 - month_start(mo, leap3) + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.second <= s3;
      out.minute <= mi3;
      out.hour <= h3;
      out.weekday <= w3;
      out.yoff <= y3;
      out.yday <= yday3;
      out.month <= mo;
      out.mday <= md;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/epoch_seconds_to_calendar.sv =====
// top level: signed epoch seconds to utc calendar fields
// each result passes through the registered stages of es2c_split and then those of es2c_fields
// throughput: one transaction per cycle, stalls freeze the whole pipeline
// while a result waits on the output the whole pipeline holds and input is refused
// reset (rst, synchronous) clears all valid bits; payload is not reset
`timescale 1ns / 1ps
`default_nettype none
module epoch_seconds_to_calendar
  import es2c_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       second,
  output logic [5:0]       minute,
  output logic [4:0]       hour,
  output logic [4:0]       month_day,
  output logic [3:0]       month,
  output logic [7:0]       years_since_1900,
  output logic [2:0]       weekday,
  output logic [8:0]       year_day
);
  logic   en;
  logic   sv, fv;
  split_t sp;
  cal_t   cal;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  es2c_split u_split (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid && en),
    .secs(epoch_seconds), .out_valid(sv), .out(sp)
  );

  es2c_fields u_fields (
    .clk(clk), .rst(rst), .en(en), .in_valid(sv),
    .in(sp), .out_valid(fv), .out(cal)
  );

  assign out_valid = fv;
  assign second = cal.second;
  assign minute = cal.minute;
  assign hour = cal.hour;
  assign month_day = cal.mday;
  assign month = cal.month;
  assign years_since_1900 = cal.yoff;
  assign weekday = cal.weekday;
  assign year_day = cal.yday;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(year_day))
    else $error("result changed while stalled");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> second < 6'd60 && minute < 6'd60 && hour < 5'd24)
    else $error("time of day out of range");
  a_mon: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> month < 4'd12 && month_day != 5'd0 && weekday < 3'd7)
    else $error("date field out of range");
endmodule
`default_nettype wire

// ===== sim/tb_epoch_seconds_to_calendar.sv =====
// self-checking testbench for the epoch seconds to calendar converter
`timescale 1ns / 1ps
module tb_epoch_seconds_to_calendar;
  import es2c_pkg::*;

  typedef struct {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] month_day;
    logic [3:0] month;
    logic [7:0] years_since_1900;
    logic [2:0] weekday;
    logic [8:0] year_day;
  } calendar_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] epoch_seconds = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] second, minute;
  logic [4:0] hour, month_day;
  logic [3:0] month;
  logic [7:0] years_since_1900;
  logic [2:0] weekday;
  logic [8:0] year_day;

  logic [31:0] pending_seconds[$];
  calendar_t expected_dates[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 0;
  bit quiet = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_off = 0;
  int accepted_in = 0;

  epoch_seconds_to_calendar DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_leap(input longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic calendar_t to_calendar(input logic [31:0] raw);
    calendar_t c;
    longint t, days, rem, yr, ylen, mlen;
    int mon;
    int lens[12];
    t = longint'($signed(raw));
    days = t / 86400;
    rem = t % 86400;
    if (rem < 0) begin
      rem += 86400;
      days -= 1;
    end
    c.hour = 5'(rem / 3600);
    c.minute = 6'((rem % 3600) / 60);
    c.second = 6'(rem % 60);
    c.weekday = 3'(((4 + days) % 7 + 7) % 7);
    yr = 1970;
    forever begin
      ylen = is_leap(yr) ? 366 : 365;
      if (days < ylen) break;
      days -= ylen;
      yr += 1;
    end
    while (days < 0) begin
      yr -= 1;
      days += is_leap(yr) ? 366 : 365;
    end
    c.year_day = 9'(days);
    lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (is_leap(yr)) lens[1] = 29;
    mon = 0;
    while (mon < 11 && days >= lens[mon]) begin
      mlen = lens[mon];
      days -= mlen;
      mon += 1;
    end
    c.month_day = 5'(days + 1);
    c.month = 4'(mon);
    c.years_since_1900 = 8'(yr - 1900);
    return c;
  endfunction

  initial begin
    logic [31:0] v;
    pending_seconds = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'd86399,
      32'd86400, 32'hfffe_ae80, 32'hfffe_ae7f, 32'd951782400, 32'd951868800,
      32'd946684799, 32'd946684800, 32'd4107542399, 32'd68169600,
      32'd1709164800, 32'd1709251199, 32'd2145916800, 32'haaaa_aaaa, 32'h5555_5555,
      32'd2117514496, 32'd1234567890};
    for (int i = 0; i < 1330; i++) begin
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = $urandom_range(0, 800) * 86400 + $urandom_range(0, 1) * 86399;
        2: v = 32'h8000_0000 + $urandom_range(0, 200000);
        default: v = $urandom_range(0, 40) * 31536000 + $urandom_range(0, 200000);
      endcase
      pending_seconds.push_back(v);
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic v_push();
    logic [31:0] s;
    s = pending_seconds.pop_front();
    epoch_seconds <= s;
    in_valid <= 1'b1;
    expected_dates.push_back(to_calendar(s));
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) accepted_in <= accepted_in + 1;
      if (in_valid && !in_ready) begin
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_seconds.size() > 0) begin
        if (!quiet && $urandom_range(0, 9) == 0) begin
          in_valid <= 1'b0;
          send_gap <= $urandom_range(1, 12) - 1;
        end else begin
          v_push();
        end
      end else begin
        in_valid <= 1'b0;
        stim_done <= 1'b1;
      end
      quiet <= pending_seconds.size() < 200;
    end
  end

  // receiver with one long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (accepted_in == 300 && hold_off == 0) begin
        hold_off <= 1;
        out_ready <= 1'b0;
      end else if (hold_off > 0 && hold_off < 200) begin
        hold_off <= hold_off + 1;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    calendar_t e;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_dates.size() == 0) begin
          $error("result with no transaction pending");
          errors++;
        end else begin
          e = expected_dates.pop_front();
          if (second !== e.second) begin
            $error("second exp %0d got %0d", e.second, second); errors++;
          end
          if (minute !== e.minute) begin
            $error("minute exp %0d got %0d", e.minute, minute); errors++;
          end
          if (hour !== e.hour) begin
            $error("hour exp %0d got %0d", e.hour, hour); errors++;
          end
          if (month_day !== e.month_day) begin
            $error("month_day exp %0d got %0d", e.month_day, month_day); errors++;
          end
          if (month !== e.month) begin
            $error("month exp %0d got %0d", e.month, month); errors++;
          end
          if (years_since_1900 !== e.years_since_1900) begin
            $error("years_since_1900 exp %0d got %0d", e.years_since_1900,
                   years_since_1900);
            errors++;
          end
          if (weekday !== e.weekday) begin
            $error("weekday exp %0d got %0d", e.weekday, weekday); errors++;
          end
          if (year_day !== e.year_day) begin
            $error("year_day exp %0d got %0d", e.year_day, year_day); errors++;
          end
        end
      end
    end
  end

  initial begin
    bit timed_out;
    timed_out = 0;
    @(negedge rst);
    while (!(stim_done && expected_dates.size() == 0) && !timed_out) begin
      @(posedge clk);
      if (idle_cycles > 2000) timed_out = 1;
    end
    if (!timed_out) repeat (20) @(posedge clk);
    if (!timed_out && errors == 0 && expected_dates.size() == 0 && out_valid !== 1'b1) begin
      $display("CHECK OK");
    end else begin
      if (expected_dates.size() != 0) $error("%0d results missing", expected_dates.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
